/* src/s20sc_pkg.sv */
// Salsa20 stream cipher package: payload types, state types, constants and helper functions.
package s20sc_pkg;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] nonce_low;
      logic [31:0] nonce_high;
      logic        first_byte;
      logic        last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] result_byte;
      logic       result_last;
   } rsp_payload_type;

   typedef logic [15:0][31:0] state_type;
   typedef logic [7:0][31:0]  key_type;

   localparam int KEY_WORDS = 8;
   localparam int CSR_INDEX_BITS = $clog2(KEY_WORDS);

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   localparam logic [4:0] LAST_ROUND = 5'd19;

   localparam logic [4:0] ROT_STEP_0 = 5'd7;
   localparam logic [4:0] ROT_STEP_1 = 5'd9;
   localparam logic [4:0] ROT_STEP_2 = 5'd13;
   localparam logic [4:0] ROT_STEP_3 = 5'd18;

   // Word positions of the four column quarter rounds, in (a, b, c, d) order.
   localparam logic [3:0] LANE_IDX [4][4] = '{
      '{4'd0,  4'd4,  4'd8,  4'd12},
      '{4'd5,  4'd9,  4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2,  4'd6},
      '{4'd15, 4'd3,  4'd7,  4'd11}
   };

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] amt);
      logic [5:0] back;
      back = 6'd32 - {1'b0, amt};
      return (v << amt) | (v >> back);
   endfunction

   function automatic state_type make_init(input key_type key, input logic [63:0] nonce,
                                           input logic [63:0] counter);
      state_type s;
      s[0]  = SIGMA_0;
      s[1]  = key[0];
      s[2]  = key[1];
      s[3]  = key[2];
      s[4]  = key[3];
      s[5]  = SIGMA_1;
      s[6]  = nonce[31:0];
      s[7]  = nonce[63:32];
      s[8]  = counter[31:0];
      s[9]  = counter[63:32];
      s[10] = SIGMA_2;
      s[11] = key[4];
      s[12] = key[5];
      s[13] = key[6];
      s[14] = key[7];
      s[15] = SIGMA_3;
      return s;
   endfunction

endpackage

/* src/salsa20_stream_cipher_unit.sv */
// Salsa20/20 byte stream cipher with a 256-bit key and a four-lane quarter-round step unit.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_stall    req_payload_type
//   rsp_      out         rsp_valid/rsp_stall    rsp_payload_type
//   csr_      in          csr_valid/csr_ready    csr_index, csr_wdata (key words 0 to 7)
//
// A byte that needs no new keystream block is transferred in, and its result is formed once
// the output register can take it. A byte that opens a block (position zero or a first byte)
// is transferred in, then passes a load step, the step unit (four lanes, one add-rotate-xor
// each, four steps per round, twenty rounds), a feed-forward step and the step that forms
// the result.
// Reset is synchronous and clears nonce, counter, byte position, key and control state.
// A stalled result holds in the output register until it is transferred.
module salsa20_stream_cipher_unit
   import s20sc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } state_enum_type;

   state_enum_type  state_ff;
   key_type         key_ff;
   logic [63:0]     nonce_ff;
   logic [63:0]     counter_ff;
   logic [5:0]      pos_ff;
   logic [4:0]      round_ff;
   logic [1:0]      step_ff;
   state_type       words_ff;
   logic [511:0]    ks_ff;
   logic [7:0]      data_ff;
   logic            last_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   state_type       init_words;
   state_type       upd_words;
   state_type       rot_words;
   state_type       words_in;
   state_type       ks_in;
   logic [4:0]      rot_amt;

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

   assign init_words = make_init(key_ff, nonce_ff, counter_ff);

   always_comb begin
      unique case (step_ff)
         2'd0: rot_amt = ROT_STEP_0;
         2'd1: rot_amt = ROT_STEP_1;
         2'd2: rot_amt = ROT_STEP_2;
         2'd3: rot_amt = ROT_STEP_3;
         default: rot_amt = ROT_STEP_0;
      endcase
   end

   // Each lane updates its b word, then the lane tuple turns by one position so the next
   // step has the same form. After the fourth step the state is transposed, which turns
   // the following column round into a row round.
   always_comb begin
      upd_words = words_ff;
      for (int l = 0; l < 4; l++) begin
         upd_words[LANE_IDX[l][1]] = words_ff[LANE_IDX[l][1]]
            ^ rotl32(words_ff[LANE_IDX[l][0]] + words_ff[LANE_IDX[l][3]], rot_amt);
      end
      rot_words = upd_words;
      for (int l = 0; l < 4; l++) begin
         for (int j = 0; j < 4; j++) begin
            rot_words[LANE_IDX[l][j]] = upd_words[LANE_IDX[l][(j + 1) % 4]];
         end
      end
      words_in = rot_words;
      if (step_ff == 2'd3) begin
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               words_in[4 * r + c] = rot_words[4 * c + r];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         ks_in[i] = words_ff[i] + init_words[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         nonce_ff     <= '0;
         counter_ff   <= '0;
         pos_ff       <= '0;
         round_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            key_ff[csr_index] <= csr_wdata;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  data_ff <= req_payload.data_byte;
                  last_ff <= req_payload.last_byte;
                  if (req_payload.first_byte) begin
                     nonce_ff   <= {req_payload.nonce_high, req_payload.nonce_low};
                     counter_ff <= '0;
                     pos_ff     <= '0;
                  end
                  if (req_payload.first_byte || pos_ff == 6'd0) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_LOAD: begin
               words_ff <= init_words;
               round_ff <= '0;
               step_ff  <= '0;
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               words_ff <= words_in;
               step_ff  <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  if (round_ff == LAST_ROUND) begin
                     round_ff <= '0;
                     state_ff <= ST_FINAL;
                  end else begin
                     round_ff <= round_ff + 5'd1;
                  end
               end
            end
            ST_FINAL: begin
               ks_ff    <= ks_in;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_payload_ff.result_byte <= data_ff ^ ks_ff[7:0];
                  rsp_payload_ff.result_last <= last_ff;
                  ks_ff                       <= ks_ff >> 8;
                  pos_ff                      <= pos_ff + 6'd1;
                  if (&pos_ff) begin
                     counter_ff <= counter_ff + 64'd1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* verif/salsa20_keystream_check.sv */
// Watches the cipher unit's channels, predicts every result byte and compares it.
`timescale 1ns / 100ps

module salsa20_keystream_check
   import s20sc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_payload_type           req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);

   localparam int DOUBLE_ROUNDS = 10;

   logic [31:0]     key_word [KEY_WORDS];
   logic [63:0]     msg_nonce;
   logic [63:0]     blk_count;
   logic [5:0]      byte_pos;
   logic [31:0]     ks_word [16];
   rsp_payload_type expected_cipher [$];
   int              mismatches;

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic logic [127:0] quarter_mix(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c, input logic [31:0] d);
      b = b ^ rotate_left(a + d, 7);
      c = c ^ rotate_left(b + a, 9);
      d = d ^ rotate_left(c + b, 13);
      a = a ^ rotate_left(d + c, 18);
      return {a, b, c, d};
   endfunction

   function automatic void refill_keystream();
      logic [31:0] start [16];
      logic [31:0] x [16];
      start[0]  = SIGMA_0;
      start[1]  = key_word[0];
      start[2]  = key_word[1];
      start[3]  = key_word[2];
      start[4]  = key_word[3];
      start[5]  = SIGMA_1;
      start[6]  = msg_nonce[31:0];
      start[7]  = msg_nonce[63:32];
      start[8]  = blk_count[31:0];
      start[9]  = blk_count[63:32];
      start[10] = SIGMA_2;
      start[11] = key_word[4];
      start[12] = key_word[5];
      start[13] = key_word[6];
      start[14] = key_word[7];
      start[15] = SIGMA_3;
      x = start;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         {x[0], x[4], x[8], x[12]}   = quarter_mix(x[0], x[4], x[8], x[12]);
         {x[5], x[9], x[13], x[1]}   = quarter_mix(x[5], x[9], x[13], x[1]);
         {x[10], x[14], x[2], x[6]}  = quarter_mix(x[10], x[14], x[2], x[6]);
         {x[15], x[3], x[7], x[11]}  = quarter_mix(x[15], x[3], x[7], x[11]);
         {x[0], x[1], x[2], x[3]}    = quarter_mix(x[0], x[1], x[2], x[3]);
         {x[5], x[6], x[7], x[4]}    = quarter_mix(x[5], x[6], x[7], x[4]);
         {x[10], x[11], x[8], x[9]}  = quarter_mix(x[10], x[11], x[8], x[9]);
         {x[15], x[12], x[13], x[14]} = quarter_mix(x[15], x[12], x[13], x[14]);
      end
      for (int i = 0; i < 16; i++) begin
         ks_word[i] = x[i] + start[i];
      end
   endfunction

   function automatic rsp_payload_type cipher_byte_predict(input req_payload_type item);
      logic [31:0]     word;
      rsp_payload_type res;
      if (item.first_byte) begin
         msg_nonce = {item.nonce_high, item.nonce_low};
         blk_count = '0;
         byte_pos  = '0;
      end
      if (byte_pos == 6'd0) begin
         refill_keystream();
      end
      word            = ks_word[byte_pos[5:2]];
      res.result_byte = item.data_byte ^ word[byte_pos[1:0] * 8 +: 8];
      res.result_last = item.last_byte;
      byte_pos        = byte_pos + 6'd1;
      if (byte_pos == 6'd0) begin
         blk_count = blk_count + 64'd1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            key_word[i] = '0;
         end
         msg_nonce = '0;
         blk_count = '0;
         byte_pos  = '0;
         expected_cipher.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            key_word[csr_index] = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_cipher.size() == 0) begin
               $error("result transfer with nothing expected: result_byte %h result_last %b",
                      rsp_payload.result_byte, rsp_payload.result_last);
               mismatches++;
            end else begin
               want = expected_cipher.pop_front();
               if (rsp_payload.result_byte !== want.result_byte) begin
                  $error("result_byte mismatch: expected %h, actual %h",
                         want.result_byte, rsp_payload.result_byte);
                  mismatches++;
               end
               if (rsp_payload.result_last !== want.result_last) begin
                  $error("result_last mismatch: expected %b, actual %b",
                         want.result_last, rsp_payload.result_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_cipher.push_back(cipher_byte_predict(req_payload));
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_cipher.size();
   end

endmodule

/* verif/tb_top.sv */
// Top of the cipher unit's testbench: clock, reset, key writes, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import s20sc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 120;
   localparam int PHASE_ITEMS    = 225;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0]               csr_wdata = '0;
   int                        fail_count;
   int                        pending_count;
   bit                        quiet = 1'b0;
   int                        idle_cycles = 0;

   always #5 clock = ~clock;

   salsa20_stream_cipher_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   salsa20_keystream_check keystream_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      int burst_left;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 18);
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end else begin
            burst_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic [63:0] nonce,
                            input bit first, input bit last);
      req_payload_type item;
      item.data_byte  = data;
      item.nonce_low  = nonce[31:0];
      item.nonce_high = nonce[63:32];
      item.first_byte = first;
      item.last_byte  = last;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_key_words(input key_type k, input int lo, input int hi);
      for (int i = lo; i <= hi; i++) begin
         csr_valid <= 1'b1;
         csr_index <= i[CSR_INDEX_BITS-1:0];
         csr_wdata <= k[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int item_goal);
      int          sent;
      int          len;
      int          kind;
      logic [63:0] nonce;
      sent = 0;
      while (sent < item_goal) begin
         kind  = $urandom_range(0, 9);
         nonce = {$urandom, $urandom};
         if (kind < 8) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 64);
            if (len > item_goal - sent) len = item_goal - sent;
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom), nonce, i == 0, i == len - 1);
            end
         end else if (kind == 8) begin
            len = $urandom_range(1, 40);
            if (len > item_goal - sent) len = item_goal - sent;
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom), {$urandom, $urandom}, 1'b0, $urandom_range(0, 7) == 0);
            end
         end else begin
            len = $urandom_range(1, 30);
            if (len > item_goal - sent) len = item_goal - sent;
            for (int i = 0; i < len; i++) begin
               send_byte(8'($urandom), {$urandom, $urandom}, $urandom_range(0, 7) == 0,
                         $urandom_range(0, 7) == 0);
            end
         end
         sent += len;
      end
   endtask

   initial begin
      key_type keys;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Stream straight after reset, without a first byte: zero key, nonce and counter.
      send_byte(8'h00, {$urandom, $urandom}, 1'b0, 1'b0);
      send_byte(8'hff, {$urandom, $urandom}, 1'b0, 1'b0);
      send_byte(8'h5a, {$urandom, $urandom}, 1'b0, 1'b1);
      drain_results();

      keys = '1;
      write_key_words(keys, 0, KEY_WORDS - 1);
      send_byte(8'hff, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
      send_byte(8'h00, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0);
      send_byte(8'h80, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1);
      // After a last byte without a new first byte the stream simply continues.
      send_byte(8'h01, 64'h0, 1'b0, 1'b0);
      // A first byte in the middle of a block restarts the message.
      send_byte(8'haa, 64'h0, 1'b1, 1'b0);
      send_byte(8'h55, 64'h0, 1'b0, 1'b0);
      send_byte(8'h7f, 64'h0, 1'b0, 1'b0);
      drain_results();

      // A key change in the middle of a block takes effect with the next block.
      keys[3] = 32'h0123_4567;
      write_key_words(keys, 3, 3);
      send_byte(8'h3c, 64'h0, 1'b0, 1'b0);
      send_byte(8'hc3, 64'h0, 1'b0, 1'b1);
      send_byte(8'h0f, 64'h1234_5678_9abc_def0, 1'b1, 1'b0);
      send_byte(8'hf0, 64'h1234_5678_9abc_def0, 1'b0, 1'b1);
      drain_results();

      keys = '0;
      write_key_words(keys, 0, KEY_WORDS - 1);
      send_byte(8'h96, 64'haaaa_aaaa_5555_5555, 1'b1, 1'b1);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            if (phase == 1) begin
               keys[i] = i[0] ? 32'h5555_5555 : 32'haaaa_aaaa;
            end else begin
               keys[i] = $urandom;
            end
         end
         write_key_words(keys, 0, KEY_WORDS - 1);
         if (phase == 3) begin
            quiet <= 1'b1;
         end
         run_phase(PHASE_ITEMS);
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
